/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, held off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/stup_pkg.sv */
// Types, constants and helper functions of the starfield star update core.
// Depends on nothing; every other file of the block but assert_macros.svh imports it.
package stup_pkg;

	// Field widths of the request and result items.
	localparam int IDX_W     = 10;
	localparam int RND_W     = 16;
	localparam int COORD_W   = 20;
	localparam int DEPTH_W   = 12;
	localparam int SPEED_W   = 2;
	localparam int SIZE_W    = 13;
	localparam int PIX_W     = 12;
	localparam int COLOR_W   = 8;
	localparam int RESP_W    = 2;
	localparam int S_TDATA_W = 80;
	localparam int M_TDATA_W = 40;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;

	// Divider geometry: 16-bit magnitude by 11-bit depth, four bits a stage.
	localparam int DVD_W      = 16;
	localparam int DVS_W      = 11;
	localparam int DIV_BPS    = 4;
	localparam int DIV_STAGES = DVD_W / DIV_BPS;

	// Width of the signed projected position before the screen test.
	localparam int FL_W = 18;

	// Spawn offset in sixteenths: half the coordinate span.
	localparam int SPAWN_OFFSET = 491520;

	// Operation codes carried in tuser.
	localparam logic OP_SPAWN   = 1'b0;
	localparam logic OP_ADVANCE = 1'b1;

	// Register index codes, taken from paddr bit 2.
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd480;
	localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd360;

	// One star entry of the table.
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [DEPTH_W-1:0] depth;
		logic [SPEED_W-1:0] speed;
	} star_t;

	// Request payload, highest bits first.
	typedef struct packed {
		logic [3:0]       pad;
		logic             ss;
		logic [RND_W-1:0] sy;
		logic [RND_W-1:0] sx;
		logic             fs;
		logic [RND_W-1:0] fy;
		logic [RND_W-1:0] fx;
		logic [IDX_W-1:0] idx;
	} in_data_t;

	// Result payload, highest bits first.
	typedef struct packed {
		logic [5:0]         pad;
		logic [RESP_W-1:0]  resp;
		logic [COLOR_W-1:0] color;
		logic [PIX_W-1:0]   py;
		logic [PIX_W-1:0]   px;
	} out_data_t;

	// Item state that travels beside the divider.
	typedef struct packed {
		logic             op;
		logic             inr;
		logic [IDX_W-1:0] idx;
		logic             resp;
		star_t            st;
		star_t            sp2;
		logic             neg_x;
		logic             neg_y;
		logic             low_x;
		logic             low_y;
	} item_t;

	// Spawn coordinate 15*r - 491520 in signed sixteenths.
	function automatic logic [COORD_W-1:0] spawn_coord(input logic [RND_W-1:0] rnd);
		logic [COORD_W:0] t;
		t = {1'b0, rnd, 4'b0000} - {5'b00000, rnd} - (COORD_W+1)'(SPAWN_OFFSET);
		return t[COORD_W-1:0];
	endfunction

endpackage

/* rtl/stup_star_mem.sv */
// Star table memory: one write port and one registered read port.
// Depends on stup_pkg for the entry type.
module stup_star_mem #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10
) (
	input  logic               clk,
	input  logic               rd_en,
	input  logic [ADDR_W-1:0]  rd_addr,
	output stup_pkg::star_t    rd_data,
	input  logic               wr_en,
	input  logic [ADDR_W-1:0]  wr_addr,
	input  stup_pkg::star_t    wr_data
);
	import stup_pkg::*;

	star_t mem_q [DEPTH];

	// Write and registered read; a read of the written address returns old data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* rtl/stup_div.sv */
// Pipelined restoring divider, four quotient bits per register stage.
// Depends on stup_pkg for the divider geometry.
module stup_div (
	input  logic                            clk,
	input  logic [stup_pkg::DIV_STAGES-1:0] en,
	input  logic [stup_pkg::DVD_W-1:0]      dividend,
	input  logic [stup_pkg::DVS_W-1:0]      divisor,
	output logic [stup_pkg::DVD_W-1:0]      quotient,
	output logic                            rem_nz
);
	import stup_pkg::*;

	logic [DVS_W-1:0] rem_s [DIV_STAGES+1];
	logic [DVD_W-1:0] wrk_s [DIV_STAGES+1];
	logic [DVS_W-1:0] dvs_s [DIV_STAGES+1];

	assign rem_s[0] = '0;
	assign wrk_s[0] = dividend;
	assign dvs_s[0] = divisor;

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		logic [DVS_W-1:0] rem_nx;
		logic [DVD_W-1:0] wrk_nx;

		// Shift in dividend bits, subtract when the trial remainder fits.
		always_comb begin
			logic [DVS_W:0] trial;
			rem_nx = rem_s[g];
			wrk_nx = wrk_s[g];
			for (int k = 0; k < DIV_BPS; k++) begin
				trial  = {rem_nx, wrk_nx[DVD_W-1]};
				wrk_nx = {wrk_nx[DVD_W-2:0], 1'b0};
				if (trial >= {1'b0, dvs_s[g]}) begin
					trial     = trial - {1'b0, dvs_s[g]};
					wrk_nx[0] = 1'b1;
				end
				rem_nx = trial[DVS_W-1:0];
			end
		end

		// Stage register, held while the stage after it is stalled.
		always_ff @(posedge clk) begin
			if (en[g]) begin
				rem_s[g+1] <= rem_nx;
				wrk_s[g+1] <= wrk_nx;
				dvs_s[g+1] <= dvs_s[g];
			end
		end
	end

	assign quotient = wrk_s[DIV_STAGES];
	assign rem_nz   = |rem_s[DIV_STAGES];

endmodule

/* rtl/starfield_star_update_projection_core.sv */
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tuser operation, s_tdata star index and random sets
// m_        out  m_tvalid/m_tready  m_tuser draw, m_tdata pixel, color, respawn count
// APB       in   psel/penable       screen width at 0x0, screen height at 0x4
//
// One request enters per cycle unless the result stalls or its star is in flight.
// The two four-stage dividers set the depth; each stage holds an item or a bubble.
// A request whose star is still in flight waits until that star is written back.
// Reset clears valid bits, sets width 480 and height 360; the star table is not cleared.
// A stalled result holds only the stages behind it that are full.
module starfield_star_update_projection_core #(
	parameter int STAR_COUNT = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [stup_pkg::APB_AW-1:0]    paddr,
	input  logic [stup_pkg::APB_DW-1:0]    pwdata,
	output logic [stup_pkg::APB_DW-1:0]    prdata,
	output logic                           pready,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [9:0] star_index, [25:10] first_x_random, [41:26] first_y_random,
	// [42] first_speed_random, [58:43] second_x_random, [74:59] second_y_random,
	// [75] second_speed_random, [79:76] zero
	input  logic [stup_pkg::S_TDATA_W-1:0] s_tdata,
	// [0] operation
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [11:0] pixel_x, [23:12] pixel_y, [31:24] color, [33:32] respawn_count,
	// [39:34] zero
	output logic [stup_pkg::M_TDATA_W-1:0] m_tdata,
	// [0] draw
	output logic                           m_tuser
);
	import stup_pkg::*;

	localparam int ADDR_W = (STAR_COUNT > 1) ? $clog2(STAR_COUNT) : 1;

	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;

	// Configuration registers.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_WIDTH:  width_q  <= pwdata[SIZE_W-1:0];
				REG_HEIGHT: height_q <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_WIDTH:  prdata = {(APB_DW-SIZE_W)'(0), width_q};
			REG_HEIGHT: prdata = {(APB_DW-SIZE_W)'(0), height_q};
			default:    prdata = '0;
		endcase
	end

	// Stage enables: a stage moves when it is empty or the next one moves.
	logic [8:1] en;
	logic [7:1] v_s;
	logic       hazard;
	in_data_t   in_w;
	in_data_t   in_s1;
	logic       op_s1;
	logic       inr_s1;
	item_t      it_s [2:7];
	logic [IDX_W-1:0] idx_at [1:7];

	always_comb begin
		en[8] = !m_tvalid || m_tready;
		for (int k = 7; k >= 1; k--) begin
			en[k] = !v_s[k] || en[k+1];
		end
	end

	// A request waits while any item in flight addresses the same star.
	assign in_w = in_data_t'(s_tdata);

	always_comb begin
		idx_at[1] = in_s1.idx;
		for (int k = 2; k <= 7; k++) begin
			idx_at[k] = it_s[k].idx;
		end
		hazard = 1'b0;
		for (int k = 1; k <= 7; k++) begin
			if (v_s[k] && (idx_at[k] == in_w.idx)) begin
				hazard = 1'b1;
			end
		end
	end

	assign s_tready = en[1] && !hazard;

	// Valid bits travel with the items.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s      <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (en[1]) begin
				v_s[1] <= s_tvalid && s_tready;
			end
			for (int k = 2; k <= 7; k++) begin
				if (en[k]) begin
					v_s[k] <= v_s[k-1];
				end
			end
			if (en[8]) begin
				m_tvalid <= v_s[7];
			end
		end
	end

	// Stage 1: request capture beside the table read.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			in_s1  <= in_w;
			op_s1  <= s_tuser;
			inr_s1 <= 32'(in_w.idx) < STAR_COUNT;
		end
	end

	star_t rd_data;
	logic  wr_en;
	star_t wr_data;

	stup_star_mem #(
		.DEPTH  (STAR_COUNT),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk     (clk),
		.rd_en   (en[1]),
		.rd_addr (ADDR_W'(in_w.idx)),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (ADDR_W'(it_s[7].idx)),
		.wr_data (wr_data)
	);

	// Front: spawn, or advance the depth and respawn on exhaustion; split the coordinates.
	item_t            it_d;
	logic [DVD_W-1:0] mag_x_d, mag_y_d;
	logic [DVD_W-1:0] mag_x_s2, mag_y_s2;
	logic [DVS_W-1:0] z_s2;

	always_comb begin
		star_t            sp1;
		logic [DEPTH_W-1:0] dec;
		logic             exh;
		logic [DVD_W-1:0] ax;
		logic [DVD_W-1:0] ay;
		sp1.x     = spawn_coord(in_s1.fx);
		sp1.y     = spawn_coord(in_s1.fy);
		sp1.depth = DEPTH_W'({1'b0, in_s1.idx} + 11'd1);
		sp1.speed = {1'b1, in_s1.fs};
		dec       = rd_data.depth - DEPTH_W'(rd_data.speed);
		exh       = dec[DEPTH_W-1] || (dec == '0);
		it_d.op   = op_s1;
		it_d.inr  = inr_s1;
		it_d.idx  = in_s1.idx;
		it_d.resp = (op_s1 == OP_ADVANCE) && exh;
		if ((op_s1 == OP_SPAWN) || exh) begin
			it_d.st = sp1;
		end else begin
			it_d.st = '{x: rd_data.x, y: rd_data.y, depth: dec, speed: rd_data.speed};
		end
		it_d.sp2.x     = spawn_coord(in_s1.sx);
		it_d.sp2.y     = spawn_coord(in_s1.sy);
		it_d.sp2.depth = DEPTH_W'({1'b0, in_s1.idx} + 11'd1);
		it_d.sp2.speed = {1'b1, in_s1.ss};
		ax         = it_d.st.x[COORD_W-1:4];
		ay         = it_d.st.y[COORD_W-1:4];
		it_d.neg_x = ax[DVD_W-1];
		it_d.neg_y = ay[DVD_W-1];
		it_d.low_x = |it_d.st.x[3:0];
		it_d.low_y = |it_d.st.y[3:0];
		mag_x_d    = it_d.neg_x ? (DVD_W'(0) - ax) : ax;
		mag_y_d    = it_d.neg_y ? (DVD_W'(0) - ay) : ay;
	end

	// Stage 2 and the side registers that follow the dividers.
	always_ff @(posedge clk) begin
		if (en[2]) begin
			it_s[2]  <= it_d;
			mag_x_s2 <= mag_x_d;
			mag_y_s2 <= mag_y_d;
			z_s2     <= it_d.st.depth[DVS_W-1:0];
		end
		for (int k = 3; k <= 7; k++) begin
			if (en[k]) begin
				it_s[k] <= it_s[k-1];
			end
		end
	end

	// Stages 3 to 6: floor(|floor(p/16)| / depth) on both axes.
	logic [DVD_W-1:0] q_x, q_y;
	logic             rnz_x, rnz_y;

	stup_div u_div_x (
		.clk      (clk),
		.en       (en[6:3]),
		.dividend (mag_x_s2),
		.divisor  (z_s2),
		.quotient (q_x),
		.rem_nz   (rnz_x)
	);

	stup_div u_div_y (
		.clk      (clk),
		.en       (en[6:3]),
		.dividend (mag_y_s2),
		.divisor  (z_s2),
		.quotient (q_y),
		.rem_nz   (rnz_y)
	);

	// Stage 7: signed floor of p/(16*depth) and whether the division was inexact.
	logic [FL_W-1:0] fl_x_s7, fl_y_s7;
	logic            ix_x_s7, ix_y_s7;

	always_ff @(posedge clk) begin
		logic [DVD_W:0] mx;
		logic [DVD_W:0] my;
		mx = {1'b0, q_x} + (DVD_W+1)'(it_s[6].neg_x && rnz_x);
		my = {1'b0, q_y} + (DVD_W+1)'(it_s[6].neg_y && rnz_y);
		if (en[7]) begin
			fl_x_s7 <= it_s[6].neg_x ? (FL_W'(0) - {1'b0, mx}) : {1'b0, mx};
			fl_y_s7 <= it_s[6].neg_y ? (FL_W'(0) - {1'b0, my}) : {1'b0, my};
			ix_x_s7 <= rnz_x || it_s[6].low_x;
			ix_y_s7 <= rnz_y || it_s[6].low_y;
		end
	end

	// Output stage: add the center, truncate toward zero, test the screen.
	logic [FL_W-1:0] sum_x, sum_y, res_x, res_y;
	logic            on_x, on_y, draw_w;
	out_data_t       out_w;

	always_comb begin
		sum_x  = FL_W'(width_q[SIZE_W-1:1]) + fl_x_s7;
		sum_y  = FL_W'(height_q[SIZE_W-1:1]) + fl_y_s7;
		res_x  = sum_x + FL_W'(sum_x[FL_W-1] && ix_x_s7);
		res_y  = sum_y + FL_W'(sum_y[FL_W-1] && ix_y_s7);
		on_x   = !res_x[FL_W-1] && (res_x < FL_W'(width_q));
		on_y   = !res_y[FL_W-1] && (res_y < FL_W'(height_q));
		draw_w = it_s[7].inr && (it_s[7].op == OP_ADVANCE) && on_x && on_y;
		out_w  = '0;
		if (it_s[7].inr && (it_s[7].op == OP_ADVANCE)) begin
			if (draw_w) begin
				out_w.px    = res_x[PIX_W-1:0];
				out_w.py    = res_y[PIX_W-1:0];
				out_w.color = COLOR_W'(({1'b0, it_s[7].idx} + 11'd1) >> 2);
				out_w.resp  = RESP_W'(it_s[7].resp);
			end else begin
				out_w.resp  = RESP_W'(it_s[7].resp) + RESP_W'(1);
			end
		end
	end

	// Write back the star as this item leaves it.
	assign wr_en   = en[8] && v_s[7] && it_s[7].inr;
	assign wr_data = ((it_s[7].op == OP_ADVANCE) && !draw_w) ? it_s[7].sp2 : it_s[7].st;

	always_ff @(posedge clk) begin
		if (en[8]) begin
			m_tdata <= out_w;
			m_tuser <= draw_w;
		end
	end

endmodule

/* rtl/stup_checker.sv */
// Port-level checks of the starfield core, attached by the bind below.
// Depends on stup_pkg and assert_macros.svh.
`include "assert_macros.svh"

module stup_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           pready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [stup_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                           m_tuser
);
	import stup_pkg::*;

	// A stalled result keeps its value.
	`ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// No pixel or color is reported for a star that is not drawn.
	`ASSERT_IMP(a_nodraw_zero, clk, arst_n, m_tvalid && !m_tuser, m_tdata[31:0] == 32'd0)

	// A drawn star never reports a respawn count of two.
	`ASSERT_IMP(a_draw_resp, clk, arst_n, m_tvalid && m_tuser, m_tdata[33:32] != 2'd2)

	// The configuration port never inserts wait states.
	`ASSERT_IMP(a_pready, clk, arst_n, 1'b1, pready)

endmodule

bind starfield_star_update_projection_core stup_checker u_stup_checker (.*);
